// File: hw/rtl/circular_doubly_linked_list_engine_defines.svh
// assertion helpers for the list engine
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define CDLL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CDLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cdll_pkg.sv
package cdll_pkg;

  localparam int unsigned PoolDepth = 32;
  localparam int unsigned IdxW      = $clog2(PoolDepth);
  localparam int unsigned CntW      = $clog2(PoolDepth + 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    OpInsFirst = 3'd0,
    OpInsLast  = 3'd1,
    OpDelFirst = 3'd2,
    OpDelLast  = 3'd3,
    OpInsAfter = 3'd4,
    OpDelValue = 3'd5,
    OpEdit     = 3'd6,
    OpTraverse = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SDecide,
    SRdTail,
    SLinkHead,
    SRdDel,
    SUnlink,
    SSearch,
    SFound,
    SInsAfter,
    SFinish,
    STravRd,
    STravOut,
    SOut
  } state_e;

endpackage

// File: hw/rtl/cdll_ram.sv
module cdll_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/circular_doubly_linked_list_engine.sv
// Circular doubly linked list of signed 32-bit values held in a pool of
// PoolDepth nodes (three RAMs: value, next link, prev link, each with one
// write and one read port). Each item carries one operation; every
// operation answers with one result item except traverse, which answers
// with one per element, marking the last with tlast. The block takes one
// item at a time. A search walks the list one node at a time (a RAM read
// then a compare) for ins_after, del_value and edit; traverse reads each
// element and then waits on the output side to hand it over. New nodes
// take the lowest free index, found by a priority encoder over the
// free map.
`include "circular_doubly_linked_list_engine_defines.svh"

module circular_doubly_linked_list_engine
  import cdll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // operation[2:0], value[34:3], new_value[66:35]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // status[1:0], item_value[33:2]
  output logic        m_axis_tlast_o
);

  state_e state_q, state_d;

  op_e         op_q;
  logic [31:0] val_q, nval_q;
  logic [PoolDepth-1:0] free_q, free_d;
  idx_t head_q, head_d;
  logic nonempty_q, nonempty_d;
  idx_t cur_q, cur_d;       // node under work
  idx_t aux_q, aux_d;       // new node
  idx_t nxt_q, nxt_d;
  idx_t prv_q, prv_d;
  cnt_t steps_q, steps_d;
  logic [1:0] sub_q, sub_d;  // micro step within a state

  logic [1:0]  ost_q, ost_d;
  logic [31:0] oval_q, oval_d;
  logic        olast_q, olast_d;

  // ram ports
  logic        v_we, n_we, p_we;
  idx_t        v_wa, n_wa, p_wa, v_ra, n_ra, p_ra;
  logic [31:0] v_wd, v_rd;
  idx_t        n_wd, p_wd, n_rd, p_rd;
  logic        n_we_m, p_we_m;
  idx_t        n_wa_m, n_wd_m, p_wa_m, p_wd_m;

  cdll_ram #(.Width(32), .Depth(PoolDepth)) u_val (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(v_ra), .rdata_o(v_rd)
  );
  cdll_ram #(.Width(IdxW), .Depth(PoolDepth)) u_next (
    .clk_i, .we_i(n_we_m), .waddr_i(n_wa_m), .wdata_i(n_wd_m), .raddr_i(n_ra),
    .rdata_o(n_rd)
  );
  cdll_ram #(.Width(IdxW), .Depth(PoolDepth)) u_prev (
    .clk_i, .we_i(p_we_m), .waddr_i(p_wa_m), .wdata_i(p_wd_m), .raddr_i(p_ra),
    .rdata_o(p_rd)
  );

  // lowest free node
  logic free_any;
  idx_t free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = PoolDepth - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_any = 1'b1;
        free_idx = idx_t'(i);
      end
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      free_q     <= '1;
      head_q     <= '0;
      nonempty_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      free_q     <= free_d;
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(s_axis_tdata_i[2:0]);
      val_q  <= s_axis_tdata_i[34:3];
      nval_q <= s_axis_tdata_i[66:35];
    end
    cur_q   <= cur_d;
    aux_q   <= aux_d;
    nxt_q   <= nxt_d;
    prv_q   <= prv_d;
    steps_q <= steps_d;
    sub_q   <= sub_d;
    ost_q   <= ost_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:   if (in_acc) state_d = SDecide;
      SDecide: begin
        unique case (op_q)
          OpInsFirst, OpInsLast: begin
            if (!free_any) state_d = SOut;
            else if (!nonempty_q) state_d = SLinkHead;
            else state_d = SRdTail;
          end
          OpDelFirst, OpDelLast: state_d = nonempty_q ? SRdDel : SOut;
          OpInsAfter, OpDelValue, OpEdit: state_d = nonempty_q ? SSearch : SOut;
          OpTraverse: state_d = nonempty_q ? STravRd : SOut;
          default: state_d = SOut;
        endcase
      end
      SRdTail:   if (sub_q == 2'd1) state_d = SLinkHead;
      SLinkHead: state_d = SOut;
      SRdDel:    if (sub_q == 2'd2) state_d = SUnlink;
      SUnlink:   state_d = SOut;
      SSearch: begin
        if (sub_q == 2'd1) begin
          if (v_rd == val_q) state_d = SFound;
          else if (n_rd == head_q || steps_q == cnt_t'(PoolDepth - 1)) state_d = SOut;
        end
      end
      SFound: begin
        unique case (op_q)
          OpInsAfter: state_d = free_any ? SInsAfter : SOut;
          OpDelValue: state_d = SRdDel;
          default:    state_d = SOut;
        endcase
      end
      SInsAfter: state_d = SOut;
      SFinish:   state_d = SOut;
      STravRd:   if (sub_q == 2'd1) state_d = STravOut;
      STravOut:  if (out_acc) state_d = olast_q ? SIdle : STravRd;
      SOut:      if (out_acc) state_d = SIdle;
      default:   state_d = SIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    free_d = free_q; head_d = head_q; nonempty_d = nonempty_q;
    cur_d = cur_q; aux_d = aux_q; nxt_d = nxt_q; prv_d = prv_q;
    steps_d = steps_q; sub_d = sub_q;
    ost_d = ost_q; oval_d = oval_q; olast_d = olast_q;
    v_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
    v_wa = cur_q; n_wa = cur_q; p_wa = cur_q;
    v_wd = nval_q; n_wd = nxt_q; p_wd = prv_q;
    v_ra = cur_q; n_ra = cur_q; p_ra = cur_q;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        s_axis_tready_o = 1'b1;
        sub_d = '0;
        steps_d = '0;
        ost_d = StOk; oval_d = '0; olast_d = 1'b1;
      end
      SDecide: begin
        sub_d = '0;
        cur_d = head_q;
        unique case (op_q)
          OpInsFirst, OpInsLast: begin
            aux_d = free_idx;
            if (!free_any) ost_d = StFull;
          end
          OpDelFirst, OpDelLast: if (!nonempty_q) ost_d = StEmpty;
          OpTraverse: if (!nonempty_q) ost_d = StEmpty;
          default: if (!nonempty_q) ost_d = StNotFound;
        endcase
      end
      SRdTail: begin
        // read prev of head, tail lands next cycle
        p_ra = head_q;
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd1) prv_d = p_rd;
      end
      SLinkHead: begin
        free_d[aux_q] = 1'b0;
        v_we = 1'b1; v_wa = aux_q; v_wd = val_q;
        n_we = 1'b1; n_wa = aux_q;
        p_we = 1'b1; p_wa = aux_q;
        if (!nonempty_q) begin
          n_wd = aux_q; p_wd = aux_q;
          head_d = aux_q; nonempty_d = 1'b1;
        end else begin
          // next of old tail and prev of head follow in the fix cycle
          n_wd = head_q; p_wd = prv_q;
          cur_d = prv_q;
          if (op_q == OpInsFirst) head_d = aux_q;
        end
      end
      SRdDel: begin
        // sub 0: for del_last fetch tail; sub 1..2: read links of cur
        sub_d = sub_q + 2'd1;
        p_ra = (sub_q == 2'd0) ? head_q : cur_q;
        n_ra = cur_q;
        if (sub_q == 2'd1 && op_q == OpDelLast && steps_q == '0) begin
          cur_d = p_rd; sub_d = 2'd0; steps_d = cnt_t'(1);
        end
        if (sub_q == 2'd0 && !(op_q == OpDelLast && steps_q == '0)) sub_d = 2'd1;
        if (sub_q == 2'd2) begin
          nxt_d = n_rd; prv_d = p_rd;
        end
      end
      SUnlink: begin
        free_d[cur_q] = 1'b1;
        if (nxt_q == cur_q) begin
          nonempty_d = 1'b0; head_d = '0;
        end else begin
          n_we = 1'b1; n_wa = prv_q; n_wd = nxt_q;
          p_we = 1'b1; p_wa = nxt_q; p_wd = prv_q;
          if (cur_q == head_q) head_d = nxt_q;
        end
      end
      SSearch: begin
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd1) begin
          sub_d = '0;
          nxt_d = n_rd;
          if (v_rd == val_q) begin
            sub_d = '0;
          end else if (n_rd == head_q || steps_q == cnt_t'(PoolDepth - 1)) begin
            ost_d = StNotFound;
          end else begin
            cur_d = n_rd; steps_d = steps_q + cnt_t'(1);
          end
        end
      end
      SFound: begin
        sub_d = '0;
        steps_d = cnt_t'(1);  // del_value already has cur
        aux_d = free_idx;
        unique case (op_q)
          OpInsAfter: if (!free_any) ost_d = StFull;
          OpDelValue: begin end
          default: begin
            v_we = 1'b1; v_wa = cur_q; v_wd = nval_q;
          end
        endcase
      end
      SInsAfter: begin
        free_d[aux_q] = 1'b0;
        v_we = 1'b1; v_wa = aux_q; v_wd = nval_q;
        n_we = 1'b1; n_wa = aux_q; n_wd = nxt_q;
        p_we = 1'b1; p_wa = aux_q; p_wd = cur_q;
      end
      SFinish: begin end
      STravRd: begin
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd1) begin
          oval_d = v_rd; nxt_d = n_rd;
          steps_d = steps_q + cnt_t'(1);
          olast_d = (n_rd == head_q) || (steps_q == cnt_t'(PoolDepth - 1));
        end
      end
      STravOut: begin
        sub_d = '0;
        if (out_acc) cur_d = nxt_q;
      end
      SOut: begin end
      default: begin end
    endcase
  end

  // second link writes that share a port are done in a fix cycle below
  logic fix_q;
  idx_t fix_n_wa_q, fix_n_wd_q, fix_p_wa_q, fix_p_wd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_q <= 1'b0;
    end else begin
      fix_q <= (state_q == SLinkHead && nonempty_q) || (state_q == SInsAfter);
    end
  end
  always_ff @(posedge clk_i) begin
    if (state_q == SLinkHead) begin
      fix_n_wa_q <= prv_q;  fix_n_wd_q <= aux_q;
      fix_p_wa_q <= head_q; fix_p_wd_q <= aux_q;
    end else begin
      fix_n_wa_q <= cur_q;  fix_n_wd_q <= aux_q;
      fix_p_wa_q <= nxt_q;  fix_p_wd_q <= aux_q;
    end
  end

  always_comb begin
    n_we_m = n_we; n_wa_m = n_wa; n_wd_m = n_wd;
    p_we_m = p_we; p_wa_m = p_wa; p_wd_m = p_wd;
    if (fix_q) begin
      n_we_m = 1'b1; n_wa_m = fix_n_wa_q; n_wd_m = fix_n_wd_q;
      p_we_m = 1'b1; p_wa_m = fix_p_wa_q; p_wd_m = fix_p_wd_q;
    end
  end

  assign m_axis_tvalid_o = (state_q == SOut && !fix_q) || (state_q == STravOut);
  assign m_axis_tdata_o  = {6'd0, oval_q, ost_q};
  assign m_axis_tlast_o  = olast_q;

  `CDLL_ASSERT_IMP(a_busy_not_ready, state_q != SIdle, !s_axis_tready_o,
    "input taken while busy")
  `CDLL_ASSERT_IMP(a_nontrav_last, m_axis_tvalid_o && state_q == SOut, m_axis_tlast_o,
    "single result not marked last")
  `CDLL_ASSERT_NEXT(a_ins_clears_free, state_q == SLinkHead, !free_q[aux_q],
    "new node still marked free")

endmodule
